// File: sv/hps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hps_pkg
// Shared types and constants of the host power sequencer.
// ----------------------------------------------------------------------------
package hps_pkg;

    // field and register widths
    localparam int unsigned PhaseW  = 4;
    localparam int unsigned ModeW   = 4;
    localparam int unsigned BlinkW  = 8;
    localparam int unsigned WinW    = 8;
    localparam int unsigned HoldW   = 10;
    localparam int unsigned PulseW  = 8;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CfgW    = 10;

    // sequencer phase codes
    localparam logic [PhaseW-1:0] PH_SETTLE   = 4'd0;
    localparam logic [PhaseW-1:0] PH_START    = 4'd1;
    localparam logic [PhaseW-1:0] PH_WAITUP   = 4'd2;
    localparam logic [PhaseW-1:0] PH_ALIVE    = 4'd3;
    localparam logic [PhaseW-1:0] PH_BOOT     = 4'd4;
    localparam logic [PhaseW-1:0] PH_RUN      = 4'd5;
    localparam logic [PhaseW-1:0] PH_PRE      = 4'd6;
    localparam logic [PhaseW-1:0] PH_SHUTWAIT = 4'd7;
    localparam logic [PhaseW-1:0] PH_PULSE    = 4'd8;
    localparam logic [PhaseW-1:0] PH_LOSS     = 4'd9;
    localparam logic [PhaseW-1:0] PH_SLEEP    = 4'd10;
    localparam logic [PhaseW-1:0] PH_WAKE     = 4'd11;

    // led modes
    localparam logic [ModeW-1:0] LED_OFF        = 4'd0;
    localparam logic [ModeW-1:0] LED_ON         = 4'd1;
    localparam logic [ModeW-1:0] LED_BLINK_FAST = 4'd2;
    localparam logic [ModeW-1:0] LED_BLINK_MID  = 4'd5;
    localparam logic [ModeW-1:0] LED_BLINK_SLOW = 4'd10;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_START_WINDOW = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_OFF_HOLD     = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_WAKE_HOLD    = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_PULSE        = 2'd3;

    // configuration reset values
    localparam logic [WinW-1:0]   RST_START_WINDOW = 8'd100;
    localparam logic [HoldW-1:0]  RST_OFF_HOLD     = 10'd500;
    localparam logic [HoldW-1:0]  RST_WAKE_HOLD    = 10'd101;
    localparam logic [PulseW-1:0] RST_PULSE        = 8'd10;

    // one result beat
    typedef struct packed {
        logic host_power_on;
        logic led_on;
        logic shutdown_request;
        logic asleep;
    } t_hps_res;

endpackage
`default_nettype wire

// File: sv/hps_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hps_in_if
// Tick channel into the sequencer: host alive level and switch level.
// ----------------------------------------------------------------------------
interface hps_in_if;
    logic valid;
    logic ready;
    logic host_alive;
    logic switch_off;

    modport source (output valid, output host_alive, output switch_off, input ready);
    modport sink   (input valid, input host_alive, input switch_off, output ready);
endinterface
`default_nettype wire

// File: sv/hps_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hps_out_if
// Result channel out of the sequencer: power, led, shutdown and sleep levels.
// ----------------------------------------------------------------------------
interface hps_out_if;
    logic valid;
    logic ready;
    logic host_power_on;
    logic led_on;
    logic shutdown_request;
    logic asleep;

    modport source (output valid, output host_power_on, output led_on,
                    output shutdown_request, output asleep, input ready);
    modport sink   (input valid, input host_power_on, input led_on,
                    input shutdown_request, input asleep, output ready);
endinterface
`default_nettype wire

// File: sv/host_power_sequencer_core.sv
// result: registered from an accepted tick beat and shown in the cycle after it
// throughput: one tick beat per cycle while the result register is empty or being taken;
//   the phase update is a single pass between the sequencer state registers and the result register
// the input is taken while a result waits, as long as the sink takes it then
// reset: synchronous; settle phase, led off, counters clear, registers default
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// host_power_sequencer_core
// Host power sequencer advanced by one 10 ms tick per input beat: sleep,
// wake hold, power enable, boot check, run, shutdown request, power loss.
// ----------------------------------------------------------------------------
module host_power_sequencer_core (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [hps_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  wire logic [hps_pkg::CfgW-1:0]    i_cfg_data,
    hps_in_if.sink                      i_in,
    hps_out_if.source                   o_out
);
    import hps_pkg::*;

    // configuration registers
    logic [WinW-1:0]   r_start_window;
    logic [HoldW-1:0]  r_off_hold;
    logic [HoldW-1:0]  r_wake_hold;
    logic [PulseW-1:0] r_pulse;

    // sequencer state
    logic [PhaseW-1:0] r_phase,     n_phase;
    logic [ModeW-1:0]  r_led_mode,  n_led_mode;
    logic [BlinkW-1:0] r_blink_cnt, n_blink_cnt;
    logic              r_led_level, n_led_level;
    logic [WinW-1:0]   r_start_cnt, n_start_cnt;
    logic [HoldW-1:0]  r_hold_cnt,  n_hold_cnt;

    // result register
    logic              r_out_valid;
    t_hps_res          r_res, n_res;

    logic              w_accept;
    logic              w_shut;
    logic [WinW:0]     w_start_nx;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_start_nx = {1'b0, r_start_cnt} + {{WinW{1'b0}}, 1'b1};

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_window <= RST_START_WINDOW;
            r_off_hold     <= RST_OFF_HOLD;
            r_wake_hold    <= RST_WAKE_HOLD;
            r_pulse        <= RST_PULSE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START_WINDOW: r_start_window <= i_cfg_data[WinW-1:0];
                CFG_OFF_HOLD:     r_off_hold     <= i_cfg_data[HoldW-1:0];
                CFG_WAKE_HOLD:    r_wake_hold    <= i_cfg_data[HoldW-1:0];
                CFG_PULSE:        r_pulse        <= i_cfg_data[PulseW-1:0];
                default: ;
            endcase
        end
    end

    // next state for one tick
    always_comb begin
        n_phase     = r_phase;
        n_led_mode  = r_led_mode;
        n_blink_cnt = r_blink_cnt;
        n_led_level = r_led_level;
        n_start_cnt = r_start_cnt;
        n_hold_cnt  = r_hold_cnt;
        w_shut      = 1'b0;

        // unused phase codes fall back to a full power-off
        if (r_phase > PH_WAKE) begin
            n_phase     = PH_SETTLE;
            n_led_mode  = LED_OFF;
            n_led_level = 1'b0;
            n_blink_cnt = '0;
            n_start_cnt = '0;
            n_hold_cnt  = '0;
        end

        // led update in the sequencing phases
        if (n_phase >= PH_START && n_phase <= PH_SHUTWAIT && n_phase != PH_PRE) begin
            if (n_led_mode == LED_OFF) begin
                n_led_level = 1'b0;
            end else if (n_led_mode == LED_ON) begin
                n_led_level = 1'b1;
            end else if (n_blink_cnt >= {{(BlinkW-ModeW){1'b0}}, n_led_mode}) begin
                n_led_level = !n_led_level;
                n_blink_cnt = '0;
            end else begin
                n_blink_cnt = n_blink_cnt + 1'b1;
            end
        end

        // phase logic
        case (n_phase)
            PH_SETTLE: begin
                n_led_level = 1'b0;
                n_hold_cnt  = n_hold_cnt + 1'b1;
                if (n_hold_cnt >= {{(HoldW-PulseW){1'b0}}, r_pulse}) begin
                    n_hold_cnt = '0;
                    n_phase    = PH_SLEEP;
                end
            end
            PH_SLEEP: begin
                n_led_level = 1'b0;
                if (!i_in.switch_off) begin
                    n_phase     = PH_WAKE;
                    n_hold_cnt  = '0;
                    n_led_level = 1'b1;
                end
            end
            PH_WAKE: begin
                n_led_level = 1'b1;
                n_hold_cnt  = n_hold_cnt + 1'b1;
                if (n_hold_cnt >= r_wake_hold) begin
                    n_hold_cnt  = '0;
                    n_phase     = PH_START;
                    n_led_mode  = LED_BLINK_MID;
                    n_blink_cnt = '0;
                end
            end
            PH_START: begin
                n_led_mode = LED_BLINK_FAST;
                n_phase    = PH_WAITUP;
            end
            PH_WAITUP, PH_ALIVE: begin
                if (n_phase == PH_WAITUP) begin
                    if (i_in.host_alive) n_phase = PH_ALIVE;
                end else begin
                    n_led_mode = LED_BLINK_SLOW;
                    if (!i_in.host_alive) begin
                        n_start_cnt = '0;
                        n_phase     = PH_BOOT;
                    end
                end
                // switch off wins and powers down
                if (i_in.switch_off) begin
                    n_phase     = PH_SETTLE;
                    n_led_mode  = LED_OFF;
                    n_led_level = 1'b0;
                    n_blink_cnt = '0;
                    n_start_cnt = '0;
                    n_hold_cnt  = '0;
                end
            end
            PH_BOOT: begin
                if (i_in.host_alive) begin
                    n_phase = PH_RUN;
                end else if (w_start_nx > {1'b0, r_start_window}) begin
                    n_phase     = PH_LOSS;
                    n_led_level = 1'b0;
                    n_hold_cnt  = '0;
                end else begin
                    n_start_cnt = w_start_nx[WinW-1:0];
                end
            end
            PH_RUN: begin
                n_led_mode = LED_ON;
                if (i_in.switch_off) begin
                    n_phase    = PH_PRE;
                    n_hold_cnt = '0;
                end
                // loss of alive wins over switch off
                if (!i_in.host_alive) begin
                    n_phase     = PH_LOSS;
                    n_led_level = 1'b0;
                    n_hold_cnt  = '0;
                end
            end
            PH_PRE: begin
                n_hold_cnt = n_hold_cnt + 1'b1;
                if (n_hold_cnt >= {{(HoldW-PulseW){1'b0}}, r_pulse}) begin
                    n_hold_cnt = '0;
                    n_led_mode = LED_BLINK_SLOW;
                    n_phase    = PH_PULSE;
                    w_shut     = 1'b1;
                end
            end
            PH_PULSE: begin
                w_shut     = 1'b1;
                n_hold_cnt = n_hold_cnt + 1'b1;
                if (n_hold_cnt >= {{(HoldW-PulseW){1'b0}}, r_pulse}) begin
                    n_hold_cnt = '0;
                    n_phase    = PH_SHUTWAIT;
                    w_shut     = 1'b0;
                end
            end
            PH_SHUTWAIT: begin
                if (!i_in.host_alive) begin
                    n_phase     = PH_LOSS;
                    n_led_level = 1'b0;
                    n_hold_cnt  = '0;
                end
            end
            default: begin
                // power loss hold
                n_led_level = 1'b0;
                n_hold_cnt  = n_hold_cnt + 1'b1;
                if (n_hold_cnt >= r_off_hold) begin
                    n_phase     = PH_SETTLE;
                    n_led_mode  = LED_OFF;
                    n_led_level = 1'b0;
                    n_blink_cnt = '0;
                    n_start_cnt = '0;
                    n_hold_cnt  = '0;
                end
            end
        endcase

        // result fields from the state after the tick
        n_res.host_power_on    = (n_phase >= PH_WAITUP) && (n_phase <= PH_PULSE);
        n_res.led_on           = n_led_level;
        n_res.shutdown_request = w_shut;
        n_res.asleep           = (n_phase == PH_SLEEP);
    end

    // state update on an accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SETTLE;
            r_led_mode  <= LED_OFF;
            r_blink_cnt <= '0;
            r_led_level <= 1'b0;
            r_start_cnt <= '0;
            r_hold_cnt  <= '0;
        end else if (w_accept) begin
            r_phase     <= n_phase;
            r_led_mode  <= n_led_mode;
            r_blink_cnt <= n_blink_cnt;
            r_led_level <= n_led_level;
            r_start_cnt <= n_start_cnt;
            r_hold_cnt  <= n_hold_cnt;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.host_power_on    = r_res.host_power_on;
    assign o_out.led_on           = r_res.led_on;
    assign o_out.shutdown_request = r_res.shutdown_request;
    assign o_out.asleep           = r_res.asleep;

    // a shutdown request only goes out with host power enabled
    a_shut_needs_power: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.shutdown_request) |-> r_res.host_power_on)
        else $error("shutdown request without host power");

    // while asleep power and led are off
    a_sleep_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.asleep) |-> (!r_res.host_power_on && !r_res.led_on))
        else $error("asleep with power or led on");

    // the hold counter is idle while sleeping
    a_sleep_hold_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SLEEP) |-> (r_hold_cnt == '0))
        else $error("hold count running in sleep");

    // a stalled result blocks new input beats
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !i_in.ready)
        else $error("input taken while result stalled");

    // no state change without an accepted beat
    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_accept) |=> $stable(r_phase))
        else $error("phase changed without a beat");

endmodule
`default_nettype wire

// File: sim/tb_host_power_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_host_power_sequencer_core
// Self-checking bench for the host power sequencer. A shadow copy of the
// sequencer tracks every accepted tick beat and queues the expected output
// levels; each result beat is compared field by field against the oldest
// entry. Directed ticks walk the main power path first, then random ticks
// steered by the shadow phase run under several register settings while
// both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_host_power_sequencer_core;
    import hps_pkg::*;

    localparam int QUIET_LIMIT = 4000;

    // shadow copy of the sequencer and its queue of expected levels
    class power_seq_shadow;
        logic [WinW-1:0]   win_limit;
        logic [HoldW-1:0]  off_limit;
        logic [HoldW-1:0]  wake_limit;
        logic [PulseW-1:0] pulse_limit;
        logic [PhaseW-1:0] seq_phase;
        logic [ModeW-1:0]  led_sel;
        logic [BlinkW-1:0] blink_cnt;
        logic              led_q;
        logic [WinW-1:0]   boot_cnt;
        logic [HoldW-1:0]  hold_cnt;
        t_hps_res          exp_levels[$];
        int errors, n_ticks, n_results, n_pulses, n_losses, n_timeouts;

        function new();
            win_limit   = RST_START_WINDOW;
            off_limit   = RST_OFF_HOLD;
            wake_limit  = RST_WAKE_HOLD;
            pulse_limit = RST_PULSE;
            power_down();
        endfunction

        function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
            case (idx)
                CFG_START_WINDOW: win_limit   = data[WinW-1:0];
                CFG_OFF_HOLD:     off_limit   = data[HoldW-1:0];
                CFG_WAKE_HOLD:    wake_limit  = data[HoldW-1:0];
                default:          pulse_limit = data[PulseW-1:0];
            endcase
        endfunction

        function int pending();
            return exp_levels.size();
        endfunction

        // a limit of zero still takes one tick
        function bit hold_step(int unsigned limit);
            hold_cnt = hold_cnt + 1'b1;
            if (hold_cnt >= limit) begin
                hold_cnt = '0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void power_down();
            seq_phase = PH_SETTLE;
            led_sel   = LED_OFF;
            led_q     = 1'b0;
            blink_cnt = '0;
            boot_cnt  = '0;
            hold_cnt  = '0;
        endfunction

        function void enter_loss();
            seq_phase = PH_LOSS;
            led_q     = 1'b0;
            hold_cnt  = '0;
            n_losses++;
        endfunction

        function void advance_led();
            if (led_sel == LED_OFF) begin
                led_q = 1'b0;
            end else if (led_sel == LED_ON) begin
                led_q = 1'b1;
            end else if (blink_cnt >= led_sel) begin
                led_q     = ~led_q;
                blink_cnt = '0;
            end else begin
                blink_cnt = blink_cnt + 1'b1;
            end
        endfunction

        // advance one tick and queue the levels it leaves
        function void take_tick(logic alive, logic sw_off);
            logic        shut;
            int unsigned next_cnt;
            t_hps_res    lv;
            shut = 1'b0;
            n_ticks++;
            if (seq_phase > PH_WAKE) power_down();
            if (seq_phase >= PH_START && seq_phase <= PH_SHUTWAIT && seq_phase != PH_PRE)
                advance_led();
            case (seq_phase)
                PH_SETTLE: begin
                    led_q = 1'b0;
                    if (hold_step(pulse_limit)) seq_phase = PH_SLEEP;
                end
                PH_SLEEP: begin
                    led_q = 1'b0;
                    if (!sw_off) begin
                        seq_phase = PH_WAKE;
                        hold_cnt  = '0;
                        led_q     = 1'b1;
                    end
                end
                PH_WAKE: begin
                    led_q = 1'b1;
                    if (hold_step(wake_limit)) begin
                        seq_phase = PH_START;
                        led_sel   = LED_BLINK_MID;
                        blink_cnt = '0;
                    end
                end
                PH_START: begin
                    led_sel   = LED_BLINK_FAST;
                    seq_phase = PH_WAITUP;
                end
                // switch off wins over alive here
                PH_WAITUP: begin
                    if (alive) seq_phase = PH_ALIVE;
                    if (sw_off) power_down();
                end
                PH_ALIVE: begin
                    led_sel = LED_BLINK_SLOW;
                    if (!alive) begin
                        boot_cnt  = '0;
                        seq_phase = PH_BOOT;
                    end
                    if (sw_off) power_down();
                end
                // boot check, count may reach 256 with the widest window
                PH_BOOT: begin
                    if (alive) begin
                        seq_phase = PH_RUN;
                    end else begin
                        next_cnt = boot_cnt + 1;
                        if (next_cnt > win_limit) begin
                            enter_loss();
                            n_timeouts++;
                        end else begin
                            boot_cnt = next_cnt[WinW-1:0];
                        end
                    end
                end
                // alive loss wins over switch off
                PH_RUN: begin
                    led_sel = LED_ON;
                    if (sw_off) begin
                        seq_phase = PH_PRE;
                        hold_cnt  = '0;
                    end
                    if (!alive) enter_loss();
                end
                PH_PRE: begin
                    if (hold_step(pulse_limit)) begin
                        led_sel   = LED_BLINK_SLOW;
                        seq_phase = PH_PULSE;
                        shut      = 1'b1;
                        n_pulses++;
                    end
                end
                PH_PULSE: begin
                    shut = 1'b1;
                    if (hold_step(pulse_limit)) begin
                        seq_phase = PH_SHUTWAIT;
                        shut      = 1'b0;
                    end
                end
                PH_SHUTWAIT: begin
                    if (!alive) enter_loss();
                end
                default: begin
                    led_q = 1'b0;
                    if (hold_step(off_limit)) power_down();
                end
            endcase
            lv.host_power_on    = (seq_phase >= PH_WAITUP && seq_phase <= PH_PULSE);
            lv.led_on           = led_q;
            lv.shutdown_request = shut;
            lv.asleep           = (seq_phase == PH_SLEEP);
            exp_levels.push_back(lv);
        endfunction

        function void field_cmp(string name, logic want, logic got);
            if (got !== want) begin
                $display("%0t: %s expected %b actual %b", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_levels(t_hps_res got);
            t_hps_res want;
            n_results++;
            if (exp_levels.size() == 0) begin
                $display("%0t: result beat with no tick pending, expected none actual %b",
                         $time, got);
                errors++;
                return;
            end
            want = exp_levels.pop_front();
            field_cmp("host_power_on", want.host_power_on, got.host_power_on);
            field_cmp("led_on", want.led_on, got.led_on);
            field_cmp("shutdown_request", want.shutdown_request, got.shutdown_request);
            field_cmp("asleep", want.asleep, got.asleep);
        endfunction
    endclass

    typedef enum int {SINK_FREE, SINK_LIGHT, SINK_HEAVY, SINK_PERIODIC} t_sink_mode;

    logic                i_clk;
    logic                i_rst_n;
    logic                cfg_we;
    logic [CfgIdxW-1:0]  cfg_idx;
    logic [CfgW-1:0]     cfg_data;

    hps_in_if  in_if ();
    hps_out_if out_if ();

    power_seq_shadow shadow;
    logic [1:0]      tick_script[$];
    int              boot_lows;
    int              gap_left;
    int              burst_left;
    int              quiet_cycles;

    // directed walk: sleep, wake, switch off racing alive, boot, loss in run
    logic [1:0] wake_script[16] = '{2'b01, 2'b00, 2'b00, 2'b00, 2'b11, 2'b01,
                                    2'b00, 2'b00, 2'b00, 2'b10, 2'b00, 2'b00,
                                    2'b00, 2'b10, 2'b01, 2'b01};

    host_power_sequencer_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // 2 ns clock
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // next tick levels {alive, switch_off}, steered by the shadow phase
    function automatic logic [1:0] next_tick();
        logic alive, sw_off;
        if (tick_script.size() != 0) return tick_script.pop_front();
        // pick how many low ticks the next boot check sees
        if (shadow.seq_phase != PH_BOOT) begin
            case ($urandom_range(0, 3))
                0:       boot_lows = shadow.win_limit;
                1:       boot_lows = shadow.win_limit + 1;
                default: boot_lows = $urandom_range(0, shadow.win_limit);
            endcase
        end
        if ($urandom_range(0, 19) == 0) return 2'($urandom_range(0, 3));
        alive  = 1'($urandom_range(0, 1));
        sw_off = 1'($urandom_range(0, 1));
        case (shadow.seq_phase)
            PH_SLEEP: sw_off = ($urandom_range(0, 3) == 0);
            PH_WAITUP: begin
                alive  = ($urandom_range(0, 2) == 0);
                sw_off = ($urandom_range(0, 29) == 0);
            end
            PH_ALIVE: begin
                alive  = ($urandom_range(0, 3) != 0);
                sw_off = ($urandom_range(0, 29) == 0);
            end
            PH_BOOT: alive = (shadow.boot_cnt >= boot_lows);
            PH_RUN: begin
                sw_off = ($urandom_range(0, 7) == 0);
                alive  = ($urandom_range(0, 39) != 0);
            end
            PH_SHUTWAIT: alive = ($urandom_range(0, 4) != 0);
            default: ;
        endcase
        return {alive, sw_off};
    endfunction

    // send tick beats in bursts with random gaps
    task automatic send_ticks(int count);
        int         sent;
        logic [1:0] tk;
        sent = 0;
        while (sent < count) begin
            @(posedge i_clk);
            if (in_if.valid && in_if.ready) begin
                shadow.take_tick(in_if.host_alive, in_if.switch_off);
                sent++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (sent < count && gap_left == 0) begin
                    tk = next_tick();
                    in_if.valid      <= 1'b1;
                    in_if.host_alive <= tk[1];
                    in_if.switch_off <= tk[0];
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(1, 12);
                    end
                end else begin
                    in_if.valid <= 1'b0;
                    if (gap_left > 0) gap_left--;
                end
            end
        end
    endtask

    // hold off until every expected result beat has arrived
    task automatic drain();
        while (shadow.pending() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic put_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        shadow.set_reg(idx, data);
    endtask

    // idle the block, load all registers, then run ticks with a pause midway
    task automatic run_phase(logic [WinW-1:0] win, logic [HoldW-1:0] off_hold,
                             logic [HoldW-1:0] wake_hold, logic [PulseW-1:0] pulse,
                             int count);
        drain();
        put_reg(CFG_START_WINDOW, CfgW'(win));
        put_reg(CFG_OFF_HOLD, CfgW'(off_hold));
        put_reg(CFG_WAKE_HOLD, CfgW'(wake_hold));
        put_reg(CFG_PULSE, CfgW'(pulse));
        @(posedge i_clk);
        cfg_we <= 1'b0;
        send_ticks(count / 2);
        drain();
        send_ticks(count - count / 2);
    endtask

    // receiver stalls on a pattern that is drawn anew at random whenever its run ends
    initial begin
        t_sink_mode  stall_mode;
        int          mode_left;
        int unsigned beat_ctr;
        out_if.ready <= 1'b0;
        stall_mode = SINK_FREE;
        mode_left  = 0;
        beat_ctr   = 0;
        forever begin
            @(posedge i_clk);
            if (mode_left == 0) begin
                stall_mode = t_sink_mode'($urandom_range(0, 3));
                mode_left  = $urandom_range(32, 256);
            end
            mode_left--;
            beat_ctr++;
            case (stall_mode)
                SINK_FREE:  out_if.ready <= 1'b1;
                SINK_LIGHT: out_if.ready <= ($urandom_range(0, 3) != 0);
                SINK_HEAVY: out_if.ready <= ($urandom_range(0, 3) == 0);
                default:    out_if.ready <= (beat_ctr % 5 != 0);
            endcase
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            shadow.check_levels({out_if.host_power_on, out_if.led_on,
                                 out_if.shutdown_request, out_if.asleep});
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("FAIL");
            $finish;
        end
    end

    // main sequence
    initial begin
        shadow = new();
        quiet_cycles = 0;
        gap_left     = 0;
        burst_left   = $urandom_range(1, 40);
        boot_lows    = 0;
        i_rst_n          <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_idx          <= CFG_START_WINDOW;
        cfg_data         <= '0;
        in_if.valid      <= 1'b0;
        in_if.host_alive <= 1'b0;
        in_if.switch_off <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // settle under reset values, then sleep with the switch off
        repeat (11) tick_script.push_back(2'b01);
        send_ticks(11);

        // directed walk with short holds
        foreach (wake_script[k]) tick_script.push_back(wake_script[k]);
        run_phase(8'd2, 10'd1, 10'd1, 8'd1, 16);

        // random ticks under a range of settings
        run_phase(8'd3, 10'd1, 10'd1, 8'd1, 250);
        run_phase(8'd0, 10'd0, 10'd0, 8'd0, 200);
        run_phase(8'($urandom_range(0, 20)), 10'($urandom_range(1, 20)),
                  10'($urandom_range(1, 20)), 8'($urandom_range(1, 8)), 250);
        run_phase(8'd255, 10'd2, 10'd3, 8'd2, 300);
        run_phase(8'd1, 10'd1, 10'd1, 8'd255, 200);
        run_phase(8'd255, 10'd1023, 10'd1023, 8'd1, 500);
        run_phase(RST_START_WINDOW, RST_OFF_HOLD, RST_WAKE_HOLD, RST_PULSE, 100);

        drain();
        repeat (4) @(posedge i_clk);
        $display("ran %0d ticks, checked %0d result beats over 8 register settings",
                 shadow.n_ticks, shadow.n_results);
        $display("saw %0d shutdown pulses, %0d power losses, %0d boot check timeouts",
                 shadow.n_pulses, shadow.n_losses, shadow.n_timeouts);
        if (shadow.errors == 0 && shadow.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
